// ===== hdl/pscu_pkg.sv =====
// Shared types, constants and helper functions for the steering correction unit.
`default_nettype none
package pscu_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_SGAIN    = 3'd3;
  localparam logic [2:0] REG_SOFFSET  = 3'd4;
  localparam logic [2:0] REG_AMIN     = 3'd5;
  localparam logic [2:0] REG_AMAX     = 3'd6;
  localparam logic [2:0] REG_FALLBACK = 3'd7;

  // Command opcodes.
  localparam logic CMD_SERVO = 1'b0;
  localparam logic CMD_GOAL  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] KP_RESET       = 32'sd65536;
  localparam logic signed [31:0] KI_RESET       = 32'sd0;
  localparam logic signed [31:0] KD_RESET       = 32'sd6554;
  localparam logic signed [31:0] SGAIN_RESET    = -32'sd79527;
  localparam logic signed [31:0] SOFFSET_RESET  = 32'sd34761;
  localparam logic signed [31:0] AMIN_RESET     = -32'sd17695;
  localparam logic signed [31:0] AMAX_RESET     = 32'sd20316;
  localparam logic [31:0]        FALLBACK_RESET = 32'd6554;

  // Operation codes of the serial arithmetic unit.
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  // Request to the serial arithmetic unit. For a multiply, a[31:0] times b;
  // for a divide, the 49-bit a divided by b. Both operands are magnitudes.
  typedef struct packed {
    logic        start;
    logic        op;
    logic [48:0] a;
    logic [31:0] b;
  } md_req_t;

  // Response of the serial arithmetic unit.
  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  // Saturate a signed 64-bit value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Apply a sign to an unsigned magnitude.
  function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] mag);
    logic signed [63:0] r;
    r = neg ? -$signed(mag) : $signed(mag);
    return r;
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value fits unsigned.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pscu_if.sv =====
// Channel interfaces: command input, result output and configuration writes.
`default_nettype none
interface pscu_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] servo_position;
  logic [31:0] steer_target;
  logic [31:0] speed_target;
  logic [31:0] elapsed_time;
  modport source (output valid, opcode, servo_position, steer_target, speed_target,
                  elapsed_time, input ready);
  modport sink (input valid, opcode, servo_position, steer_target, speed_target,
                elapsed_time, output ready);
endinterface

interface pscu_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] steer_out;
  logic [31:0] speed_out;
  modport source (output valid, steer_out, speed_out, input ready);
  modport sink (input valid, steer_out, speed_out, output ready);
endinterface

interface pscu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pid_steering_correction_unit.sv =====
// Top level of the PID steering correction unit with output clamp.
`default_nettype none
// One shared bit-serial arithmetic unit does every multiply and divide, one
// bit per cycle. A servo sample (one divide) occupies the block and gives
// no result; a goal command (one multiply, one divide, three more multiplies)
// ends with its result loaded into the output register. A new command is
// taken only when the previous one is finished; a waiting result does not
// block the next command. Configuration writes are taken in any cycle and
// should only be issued while the block is idle.
module pid_steering_correction_unit
  import pscu_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  pscu_cmd_if.sink   cmd,
  pscu_res_if.source res,
  pscu_cfg_if.sink   cfg
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SDIV = 8'b00000010,
    S_EMUL = 8'b00000100,
    S_DDIV = 8'b00001000,
    S_KP   = 8'b00010000,
    S_KI   = 8'b00100000,
    S_KD   = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state;

  logic signed [31:0] kp, ki, kd, sgain, soffset, amin, amax;
  logic [31:0]        fallback;

  logic signed [31:0] measured_angle, error_integral, last_error;
  logic signed [31:0] target, speed, err, deriv;
  logic [31:0]        dt;
  logic               neg;
  logic signed [63:0] corr_acc;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic               res_valid;
  logic [31:0]        res_steer, res_speed;

  logic               cmd_fire;
  logic signed [32:0] sdiff;
  logic [32:0]        sdiff_mag;
  logic signed [32:0] tdiff;
  logic signed [31:0] err_new;
  logic [31:0]        dt_new;
  logic signed [32:0] ddiff;
  logic [32:0]        ddiff_mag;
  logic signed [63:0] q_signed;
  logic signed [63:0] m_signed;
  logic signed [31:0] integral_new;
  logic signed [31:0] deriv_new;
  logic signed [31:0] corr_sat;
  logic signed [32:0] angle;
  logic signed [32:0] angle_lim;
  logic signed [31:0] angle_clamped;

  pscu_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // Operand preparation and result conversion.
  always_comb begin
    sdiff     = {cmd.servo_position[31], cmd.servo_position} - {soffset[31], soffset};
    sdiff_mag = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    tdiff     = {cmd.steer_target[31], cmd.steer_target} - {measured_angle[31], measured_angle};
    err_new   = sat32(64'(tdiff));
    if (cmd.elapsed_time != 32'd0) begin
      dt_new = cmd.elapsed_time;
    end else if (fallback != 32'd0) begin
      dt_new = fallback;
    end else begin
      dt_new = 32'd1;
    end
    ddiff        = {err[31], err} - {last_error[31], last_error};
    ddiff_mag    = ddiff[32] ? 33'(-ddiff) : 33'(ddiff);
    q_signed     = apply_sign(neg, {15'd0, md_rsp.result[48:0]});
    m_signed     = apply_sign(neg, {16'd0, md_rsp.result[63:16]});
    integral_new = sat32(64'(error_integral) + m_signed);
    deriv_new    = sat32(q_signed);
    corr_sat     = sat32(corr_acc + m_signed);
    angle        = {target[31], target} + {corr_sat[31], corr_sat};
    // The upper limit is applied first, so the lower limit wins when crossed.
    if (angle > 33'(amax)) begin
      angle_lim = 33'(amax);
    end else begin
      angle_lim = angle;
    end
    if (angle_lim < 33'(amin)) begin
      angle_clamped = amin;
    end else begin
      angle_clamped = angle_lim[31:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp       <= KP_RESET;
      ki       <= KI_RESET;
      kd       <= KD_RESET;
      sgain    <= SGAIN_RESET;
      soffset  <= SOFFSET_RESET;
      amin     <= AMIN_RESET;
      amax     <= AMAX_RESET;
      fallback <= FALLBACK_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KP:       kp       <= cfg.data;
        REG_KI:       ki       <= cfg.data;
        REG_KD:       kd       <= cfg.data;
        REG_SGAIN:    sgain    <= cfg.data;
        REG_SOFFSET:  soffset  <= cfg.data;
        REG_AMIN:     amin     <= cfg.data;
        REG_AMAX:     amax     <= cfg.data;
        REG_FALLBACK: fallback <= cfg.data;
        default:      ;
      endcase
    end
  end

  // Command sequencer and PID state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      md_req.start   <= 1'b0;
      measured_angle <= '0;
      error_integral <= '0;
      last_error     <= '0;
      res_valid      <= 1'b0;
    end else begin
      // The output register is loaded from the finishing state and emptied
      // when its transaction is accepted.
      if (state == S_DONE && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire && cmd.opcode == CMD_GOAL) begin
            target <= cmd.steer_target;
            speed  <= cmd.speed_target;
            dt     <= dt_new;
            err    <= err_new;
            md_req <= '{start: 1'b1, op: OP_MUL, a: {17'd0, mag32(err_new)}, b: dt_new};
            neg    <= err_new[31];
            state  <= S_EMUL;
          end else if (cmd_fire && sgain != 32'sd0) begin
            md_req <= '{start: 1'b1, op: OP_DIV, a: {sdiff_mag, 16'd0},
                        b: mag32(sgain)};
            neg    <= sdiff[32] ^ sgain[31];
            state  <= S_SDIV;
          end else begin
            md_req.start <= 1'b0;
          end
        end
        S_SDIV: begin
          md_req.start <= 1'b0;
          if (md_rsp.done) begin
            measured_angle <= sat32(q_signed);
            state          <= S_IDLE;
          end
        end
        S_EMUL: begin
          if (md_rsp.done) begin
            error_integral <= integral_new;
            last_error     <= err;
            md_req <= '{start: 1'b1, op: OP_DIV, a: {ddiff_mag, 16'd0}, b: dt};
            neg    <= ddiff[32];
            state  <= S_DDIV;
          end else begin
            md_req.start <= 1'b0;
          end
        end
        S_DDIV: begin
          if (md_rsp.done) begin
            deriv    <= deriv_new;
            corr_acc <= '0;
            md_req   <= '{start: 1'b1, op: OP_MUL, a: {17'd0, mag32(err)}, b: mag32(kp)};
            neg      <= kp[31] ^ err[31];
            state    <= S_KP;
          end else begin
            md_req.start <= 1'b0;
          end
        end
        S_KP: begin
          if (md_rsp.done) begin
            corr_acc <= corr_acc + m_signed;
            md_req   <= '{start: 1'b1, op: OP_MUL, a: {17'd0, mag32(error_integral)},
                          b: mag32(ki)};
            neg      <= ki[31] ^ error_integral[31];
            state    <= S_KI;
          end else begin
            md_req.start <= 1'b0;
          end
        end
        S_KI: begin
          if (md_rsp.done) begin
            corr_acc <= corr_acc + m_signed;
            md_req   <= '{start: 1'b1, op: OP_MUL, a: {17'd0, mag32(deriv)}, b: mag32(kd)};
            neg      <= kd[31] ^ deriv[31];
            state    <= S_KD;
          end else begin
            md_req.start <= 1'b0;
          end
        end
        S_KD: begin
          md_req.start <= 1'b0;
          if (md_rsp.done) begin
            target <= angle_clamped;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          md_req.start <= 1'b0;
          if (!res_valid || res.ready) begin
            res_steer <= target;
            res_speed <= speed;
            state     <= S_IDLE;
          end
        end
        default: begin
          md_req.start <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid     = res_valid;
  assign res.steer_out = res_steer;
  assign res.speed_out = res_speed;

`ifndef SYNTHESIS
  // A goal command always starts with the error times time step product.
  a_goal_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.opcode) |=> (state == S_EMUL && md_req.start))
    else $error("goal command did not start the integral product");

  // The measured angle only changes when a servo divide completes.
  a_angle_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(measured_angle) |-> $past(state == S_SDIV && md_rsp.done))
    else $error("measured angle changed outside a servo sample");

  // A new result is only loaded from the finishing state.
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside the finishing state");
`endif

endmodule
`default_nettype wire

// ===== hdl/pscu_muldiv.sv =====
// Bit-serial unsigned shift-add multiplier and restoring divider.
`default_nettype none
module pscu_muldiv
  import pscu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  md_req_t   req,
  output md_rsp_t   rsp
);

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd48;

  logic        busy;
  logic        op;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] p;
  logic [63:0] p_next;
  logic [31:0] d;
  logic [31:0] rem;
  logic [31:0] rem_next;
  logic [32:0] mul_sum;
  logic [32:0] div_shift;
  logic        div_ge;

  // One multiplier bit or one quotient bit per cycle.
  always_comb begin
    mul_sum   = {1'b0, p[63:32]} + (p[0] ? {1'b0, d} : 33'd0);
    div_shift = {rem, p[48]};
    div_ge    = (div_shift >= {1'b0, d});
    if (op == OP_DIV) begin
      rem_next = div_ge ? 32'(div_shift - {1'b0, d}) : div_shift[31:0];
      p_next   = {p[63:49], p[47:0], div_ge};
    end else begin
      rem_next = rem;
      p_next   = {mul_sum, p[31:1]};
    end
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        d    <= req.b;
        rem  <= '0;
        p    <= (req.op == OP_DIV) ? {15'd0, req.a} : {32'd0, req.a[31:0]};
      end else if (busy) begin
        p   <= p_next;
        rem <= rem_next;
        cnt <= cnt + 6'd1;
        if (cnt == ((op == OP_DIV) ? DIV_LAST : MUL_LAST)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = p;

endmodule
`default_nettype wire
